/* rtl/bicubic_interpolator_macros.svh */
// Assertion macros for the bicubic interpolator.
`ifndef BICUBIC_INTERPOLATOR_MACROS_SVH
`define BICUBIC_INTERPOLATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define BICUB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BICUB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BICUB_ASSERT(lbl, clk, rst_n, prop, msg)
`define BICUB_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* rtl/bicub_pkg.sv */
// Shared widths, codes and control types of the bicubic interpolator.
package bicub_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int COL_W    = 18;   // kept column value, Q17.1
    localparam int A_W      = 21;   // doubled cubic coefficients
    localparam int B_W      = 22;
    localparam int C_W      = 19;
    localparam int D_W      = 19;
    localparam int H_W      = 40;   // Horner accumulator, Q.16
    localparam int IDX_W    = 2;
    localparam int NUM_KEPT = 3;

    localparam logic [IDX_W-1:0] LAST_COL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF,
        S_MAC,
        S_ROUND
    } t_state;

    typedef enum logic [1:0] {
        SEL_B,
        SEL_C,
        SEL_D
    } t_coef_sel;

    typedef struct packed {
        logic      load_in;
        logic      load_coef;
        logic      mac_en;
        t_coef_sel coef_sel;
        logic      store_col;
        logic      start_horiz;
        logic      load_out;
    } t_ctrl;

endpackage

/* rtl/bicubic_interpolator.sv */
// Catmull-Rom bicubic interpolator top level, one shared Horner multiplier.
// Columns 0..2: each beat loads coefficients, takes three Horner steps and rounds into a kept column.
// Column 3: its rounded column starts the horizontal pass; the result loads once the held output is free.
// o_stall is high from each accepted beat until the sequencer is idle again, so no new beat is taken before.
// Synchronous active-low reset clears the sequencer, output valid and kept columns.
`include "bicubic_interpolator_macros.svh"

module bicubic_interpolator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [bicub_pkg::SAMPLE_W-1:0] i_sample_0,
    input  logic signed [bicub_pkg::SAMPLE_W-1:0] i_sample_1,
    input  logic signed [bicub_pkg::SAMPLE_W-1:0] i_sample_2,
    input  logic signed [bicub_pkg::SAMPLE_W-1:0] i_sample_3,
    input  logic        [bicub_pkg::IDX_W-1:0]    i_col_index,
    input  logic        [bicub_pkg::FRAC_W-1:0]   i_frac_y,
    input  logic        [bicub_pkg::FRAC_W-1:0]   i_frac_x,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [bicub_pkg::SAMPLE_W-1:0] o_value
);

    localparam int COL_W    = bicub_pkg::COL_W;
    localparam int SAMPLE_W = bicub_pkg::SAMPLE_W;
    localparam int FRAC_W   = bicub_pkg::FRAC_W;
    localparam int H_W      = bicub_pkg::H_W;
    localparam int EXT      = COL_W - SAMPLE_W;
    localparam int OSH      = FRAC_W + 2;    // horizontal result is 4v in Q.16

    bicub_pkg::t_ctrl w_ctrl;
    logic             w_busy;
    logic             w_in_fire;
    logic             w_out_fire;

    logic signed [COL_W-1:0]  r_p [4];
    logic signed [COL_W-1:0]  r_kept [bicub_pkg::NUM_KEPT];
    logic [FRAC_W-1:0]        r_t, r_tx;
    logic [bicub_pkg::IDX_W-1:0] r_idx;
    logic signed [bicub_pkg::B_W-1:0] r_b;
    logic signed [bicub_pkg::C_W-1:0] r_c;
    logic signed [bicub_pkg::D_W-1:0] r_d;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_out_valid;

    logic signed [bicub_pkg::A_W-1:0] w_a;
    logic signed [bicub_pkg::B_W-1:0] w_b;
    logic signed [bicub_pkg::C_W-1:0] w_c;
    logic signed [bicub_pkg::D_W-1:0] w_d;
    logic signed [bicub_pkg::B_W-1:0] w_coef;
    logic signed [H_W-1:0]            w_h;
    logic signed [H_W-1:0]            w_hc, w_ho;
    logic [H_W-FRAC_W-1:0]            w_col_full;
    logic [H_W-OSH-1:0]               w_out_full;
    logic signed [COL_W-1:0]          w_col;
    logic signed [SAMPLE_W-1:0]       w_out;

    assign w_in_fire  = i_valid && !w_busy;
    assign w_out_fire = r_out_valid && !i_stall;

    bicub_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_last_col (r_idx == bicub_pkg::LAST_COL),
        .i_out_free (!r_out_valid || !i_stall),
        .o_ctrl     (w_ctrl),
        .o_busy     (w_busy)
    );

    bicub_coef u_coef (
        .i_p0 (r_p[0]),
        .i_p1 (r_p[1]),
        .i_p2 (r_p[2]),
        .i_p3 (r_p[3]),
        .o_a  (w_a),
        .o_b  (w_b),
        .o_c  (w_c),
        .o_d  (w_d)
    );

    always_comb begin
        case (w_ctrl.coef_sel)
            bicub_pkg::SEL_B: w_coef = r_b;
            bicub_pkg::SEL_C: w_coef = {{(bicub_pkg::B_W-bicub_pkg::C_W){r_c[bicub_pkg::C_W-1]}},
                                        r_c};
            default:          w_coef = {{(bicub_pkg::B_W-bicub_pkg::D_W){r_d[bicub_pkg::D_W-1]}},
                                        r_d};
        endcase
    end

    bicub_mac u_mac (
        .i_clk  (i_clk),
        .i_load (w_ctrl.load_coef),
        .i_a    (w_a),
        .i_en   (w_ctrl.mac_en),
        .i_coef (w_coef),
        .i_t    (r_t),
        .o_h    (w_h)
    );

    // round half up, then saturate when the dropped high bits are not all sign
    assign w_hc       = w_h + (H_W'(1) <<< (FRAC_W - 1));
    assign w_col_full = w_hc[H_W-1:FRAC_W];
    always_comb begin
        if ((&w_col_full[H_W-FRAC_W-1:COL_W-1]) ||
            !(|w_col_full[H_W-FRAC_W-1:COL_W-1])) begin
            w_col = w_col_full[COL_W-1:0];
        end else if (w_col_full[H_W-FRAC_W-1]) begin
            w_col = {1'b1, {(COL_W-1){1'b0}}};
        end else begin
            w_col = {1'b0, {(COL_W-1){1'b1}}};
        end
    end

    assign w_ho       = w_h + (H_W'(1) <<< (OSH - 1));
    assign w_out_full = w_ho[H_W-1:OSH];
    always_comb begin
        if ((&w_out_full[H_W-OSH-1:SAMPLE_W-1]) ||
            !(|w_out_full[H_W-OSH-1:SAMPLE_W-1])) begin
            w_out = w_out_full[SAMPLE_W-1:0];
        end else if (w_out_full[H_W-OSH-1]) begin
            w_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            w_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_in) begin
            r_p[0] <= {{EXT{i_sample_0[SAMPLE_W-1]}}, i_sample_0};
            r_p[1] <= {{EXT{i_sample_1[SAMPLE_W-1]}}, i_sample_1};
            r_p[2] <= {{EXT{i_sample_2[SAMPLE_W-1]}}, i_sample_2};
            r_p[3] <= {{EXT{i_sample_3[SAMPLE_W-1]}}, i_sample_3};
            r_t    <= i_frac_y;
            r_tx   <= i_frac_x;
            r_idx  <= i_col_index;
        end else if (w_ctrl.start_horiz) begin
            r_p[0] <= r_kept[0];
            r_p[1] <= r_kept[1];
            r_p[2] <= r_kept[2];
            r_p[3] <= w_col;
            r_t    <= r_tx;
        end
        if (w_ctrl.load_coef) begin
            r_b <= w_b;
            r_c <= w_c;
            r_d <= w_d;
        end
        if (w_ctrl.load_out) begin
            r_out <= w_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept[0]   <= '0;
            r_kept[1]   <= '0;
            r_kept[2]   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctrl.store_col) begin
                r_kept[r_idx] <= w_col;
            end
            if (w_ctrl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stall = w_busy;
    assign o_valid = r_out_valid;
    assign o_value = r_out;

    `BICUB_ASSERT(a_out_free, i_clk, i_rst_n, w_ctrl.load_out |-> (!r_out_valid || !i_stall), "output overwritten while held")
    `BICUB_ASSERT_NEVER(a_store_last, i_clk, i_rst_n, w_ctrl.store_col && (r_idx == bicub_pkg::LAST_COL), "last column stored")
    `BICUB_ASSERT(a_busy_after_beat, i_clk, i_rst_n, w_in_fire |=> o_stall, "not busy after input beat")
    `BICUB_ASSERT(a_valid_from_load, i_clk, i_rst_n, $rose(o_valid) |-> $past(w_ctrl.load_out), "output valid without a result")

endmodule

/* rtl/bicub_coef.sv */
// Doubled Catmull-Rom coefficients from four points.
module bicub_coef (
    input  logic signed [bicub_pkg::COL_W-1:0] i_p0,
    input  logic signed [bicub_pkg::COL_W-1:0] i_p1,
    input  logic signed [bicub_pkg::COL_W-1:0] i_p2,
    input  logic signed [bicub_pkg::COL_W-1:0] i_p3,
    output logic signed [bicub_pkg::A_W-1:0]   o_a,
    output logic signed [bicub_pkg::B_W-1:0]   o_b,
    output logic signed [bicub_pkg::C_W-1:0]   o_c,
    output logic signed [bicub_pkg::D_W-1:0]   o_d
);

    localparam int EXT = bicub_pkg::B_W + 1 - bicub_pkg::COL_W;

    logic signed [bicub_pkg::B_W:0] w_e0, w_e1, w_e2, w_e3;
    logic signed [bicub_pkg::B_W:0] w_d12, w_a, w_b, w_c, w_d;

    assign w_e0 = {{EXT{i_p0[bicub_pkg::COL_W-1]}}, i_p0};
    assign w_e1 = {{EXT{i_p1[bicub_pkg::COL_W-1]}}, i_p1};
    assign w_e2 = {{EXT{i_p2[bicub_pkg::COL_W-1]}}, i_p2};
    assign w_e3 = {{EXT{i_p3[bicub_pkg::COL_W-1]}}, i_p3};

    // 2a = (p3 - p0) + 3(p1 - p2)
    assign w_d12 = w_e1 - w_e2;
    assign w_a   = (w_e3 - w_e0) + w_d12 + (w_d12 <<< 1);
    assign w_b   = (w_e0 + w_e2) - (w_e1 <<< 1) - w_a;
    assign w_c   = w_e2 - w_e0;
    assign w_d   = w_e1 <<< 1;

    assign o_a = w_a[bicub_pkg::A_W-1:0];
    assign o_b = w_b[bicub_pkg::B_W-1:0];
    assign o_c = w_c[bicub_pkg::C_W-1:0];
    assign o_d = w_d[bicub_pkg::D_W-1:0];

endmodule

/* rtl/bicub_mac.sv */
// Shared Horner step unit: h = (coef << 16) + floor(h * t / 2^16).
module bicub_mac (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic signed [bicub_pkg::A_W-1:0]   i_a,
    input  logic                               i_en,
    input  logic signed [bicub_pkg::B_W-1:0]   i_coef,
    input  logic        [bicub_pkg::FRAC_W-1:0] i_t,
    output logic signed [bicub_pkg::H_W-1:0]   o_h
);

    localparam int H_W    = bicub_pkg::H_W;
    localparam int FRAC_W = bicub_pkg::FRAC_W;
    localparam int P_W    = H_W + FRAC_W + 1;

    logic signed [H_W-1:0] r_h;
    logic signed [P_W-1:0] w_prod;
    logic signed [P_W-1:0] w_shift;
    logic signed [H_W-1:0] w_coef;
    logic signed [H_W-1:0] w_a;

    assign w_prod  = r_h * $signed({1'b0, i_t});
    assign w_shift = w_prod >>> FRAC_W;
    assign w_coef  = {{(H_W-bicub_pkg::B_W-FRAC_W){i_coef[bicub_pkg::B_W-1]}},
                      i_coef, {FRAC_W{1'b0}}};
    assign w_a     = {{(H_W-bicub_pkg::A_W-FRAC_W){i_a[bicub_pkg::A_W-1]}},
                      i_a, {FRAC_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_h <= w_a;
        end else if (i_en) begin
            r_h <= w_coef + w_shift[H_W-1:0];
        end
    end

    assign o_h = r_h;

endmodule

/* rtl/bicub_ctrl.sv */
// Sequencer for the vertical and horizontal cubic passes.
module bicub_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_fire,
    input  logic               i_last_col,
    input  logic               i_out_free,
    output bicub_pkg::t_ctrl   o_ctrl,
    output logic               o_busy
);

    bicub_pkg::t_state    r_state, n_state;
    bicub_pkg::t_coef_sel r_sel, n_sel;
    logic                 r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bicub_pkg::S_IDLE;
            r_sel   <= bicub_pkg::SEL_B;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_pass  = r_pass;
        o_ctrl  = '0;
        o_ctrl.coef_sel = r_sel;
        case (r_state)
            bicub_pkg::S_IDLE: begin
                if (i_in_fire) begin
                    o_ctrl.load_in = 1'b1;
                    n_pass  = 1'b0;
                    n_state = bicub_pkg::S_COEF;
                end
            end
            bicub_pkg::S_COEF: begin
                o_ctrl.load_coef = 1'b1;
                n_sel   = bicub_pkg::SEL_B;
                n_state = bicub_pkg::S_MAC;
            end
            bicub_pkg::S_MAC: begin
                o_ctrl.mac_en = 1'b1;
                case (r_sel)
                    bicub_pkg::SEL_B: n_sel = bicub_pkg::SEL_C;
                    bicub_pkg::SEL_C: n_sel = bicub_pkg::SEL_D;
                    default:          n_state = bicub_pkg::S_ROUND;
                endcase
            end
            bicub_pkg::S_ROUND: begin
                if (!r_pass) begin
                    if (i_last_col) begin
                        // column 3 feeds the horizontal pass
                        o_ctrl.start_horiz = 1'b1;
                        n_pass  = 1'b1;
                        n_state = bicub_pkg::S_COEF;
                    end else begin
                        o_ctrl.store_col = 1'b1;
                        n_state = bicub_pkg::S_IDLE;
                    end
                end else if (i_out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state = bicub_pkg::S_IDLE;
                end
            end
            default: n_state = bicub_pkg::S_IDLE;
        endcase
    end

    assign o_busy = (r_state != bicub_pkg::S_IDLE);

endmodule
